@@ sv/vcdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vcdt_pkg
// shared types and constants of the visited cell direction table
// ----------------------------------------------------------------------------
package vcdt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int COORD_BITS    = 8;
	localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

	typedef logic [COORD_BITS-1:0] coord_t;

	// bit 0 left, bit 1 right, bit 2 up, bit 3 down
	typedef logic [3:0] flags_t;

	typedef enum logic [1:0] {
		OP_STORE    = 2'd0,
		OP_LOAD     = 2'd1,
		OP_CHECK    = 2'd2,
		OP_NEIGHBOR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		HEAD_LEFT  = 2'd0,
		HEAD_RIGHT = 2'd1,
		HEAD_UP    = 2'd2,
		HEAD_DOWN  = 2'd3
	} heading_t;

	typedef struct packed {
		coord_t col;
		coord_t row;
		flags_t flags;
	} entry_t;

	typedef struct packed {
		op_t      op;
		coord_t   col;
		coord_t   row;
		flags_t   flags;
		heading_t heading;
	} req_t;

	typedef struct packed {
		logic   full;
		flags_t flags;
		logic   exhausted;
		logic   found;
	} res_t;

endpackage
`default_nettype wire

@@ sv/vcdt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vcdt_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module vcdt_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 20
) (
	input  wire logic                                         clk,
	input  wire logic                                         wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                             wr_data,
	input  wire logic                                         rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ sv/vcdt_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vcdt_engine
// sequential lookup over the entry ram, flag update or append, result build
// ----------------------------------------------------------------------------
module vcdt_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire vcdt_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_ready,
	output vcdt_pkg::res_t      res
);
	import vcdt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   issue_q;
	logic                  chk_valid_s1;
	logic [IDX_BITS-1:0]   chk_idx_s1;
	op_t                   op_q;
	coord_t                col_q;
	coord_t                row_q;
	flags_t                flags_q;
	logic                  skip_q;
	res_t                  res_q;

	coord_t                nb_col;
	coord_t                nb_row;
	logic                  on_grid;

	logic                  rd_en;
	logic [IDX_BITS-1:0]   rd_addr;
	entry_t                rd_data;
	logic                  wr_en;
	logic [IDX_BITS-1:0]   wr_addr;
	entry_t                wr_data;

	logic                  match;
	logic                  last;
	logic                  hit_now;
	logic                  miss_now;
	logic                  room;

	vcdt_ram #(
		.DEPTH (TABLE_ENTRIES),
		.WIDTH ($bits(entry_t))
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// neighbour coordinate and grid edge test
	always_comb begin
		nb_col  = req.col;
		nb_row  = req.row;
		on_grid = 1'b1;
		if (req.op == OP_NEIGHBOR) begin
			unique case (req.heading)
				HEAD_LEFT: begin
					if (req.col == '0) on_grid = 1'b0;
					else nb_col = req.col - coord_t'(1);
				end
				HEAD_RIGHT: begin
					if (req.col == '1) on_grid = 1'b0;
					else nb_col = req.col + coord_t'(1);
				end
				HEAD_UP: begin
					if (req.row == '0) on_grid = 1'b0;
					else nb_row = req.row - coord_t'(1);
				end
				HEAD_DOWN: begin
					if (req.row == '1) on_grid = 1'b0;
					else nb_row = req.row + coord_t'(1);
				end
				default: on_grid = 1'b1;
			endcase
		end
	end

	assign rd_en   = (state_q == ST_SCAN) && !skip_q && (issue_q < count_q);
	assign rd_addr = issue_q[IDX_BITS-1:0];

	assign match    = (rd_data.col == col_q) && (rd_data.row == row_q);
	assign last     = (CNT_BITS'(chk_idx_s1) == (count_q - CNT_BITS'(1)));
	assign hit_now  = (state_q == ST_SCAN) && !skip_q && chk_valid_s1 && match;
	assign miss_now = (state_q == ST_SCAN) && !hit_now &&
	                  (skip_q || (count_q == '0) || (chk_valid_s1 && last));
	assign room     = (count_q < CNT_BITS'(TABLE_ENTRIES));

	assign wr_en         = (op_q == OP_STORE) && (hit_now || (miss_now && room));
	assign wr_addr       = hit_now ? chk_idx_s1 : count_q[IDX_BITS-1:0];
	assign wr_data.col   = col_q;
	assign wr_data.row   = row_q;
	assign wr_data.flags = flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			issue_q      <= '0;
			chk_valid_s1 <= 1'b0;
			chk_idx_s1   <= '0;
			op_q         <= OP_STORE;
			col_q        <= '0;
			row_q        <= '0;
			flags_q      <= '0;
			skip_q       <= 1'b0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q         <= req.op;
						col_q        <= nb_col;
						row_q        <= nb_row;
						flags_q      <= req.flags;
						skip_q       <= !on_grid;
						issue_q      <= '0;
						chk_valid_s1 <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_valid_s1 <= rd_en;
					chk_idx_s1   <= issue_q[IDX_BITS-1:0];
					if (rd_en) begin
						issue_q <= issue_q + CNT_BITS'(1);
					end
					if (hit_now) begin
						res_q.found <= 1'b1;
						res_q.full  <= 1'b0;
						if (op_q == OP_STORE) begin
							res_q.flags     <= '0;
							res_q.exhausted <= 1'b0;
						end else begin
							res_q.flags     <= rd_data.flags;
							res_q.exhausted <= (rd_data.flags == '0);
						end
						state_q <= ST_DONE;
					end else if (miss_now) begin
						res_q.found     <= 1'b0;
						res_q.exhausted <= 1'b0;
						if (op_q == OP_STORE) begin
							res_q.flags <= '0;
							res_q.full  <= !room;
							if (room) begin
								count_q <= count_q + CNT_BITS'(1);
							end
						end else begin
							res_q.flags <= '1;
							res_q.full  <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

endmodule
`default_nettype wire

@@ sv/visited_cell_direction_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// visited_cell_direction_table
// coordinate keyed table of untried direction flags with stream ports
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The table lives in a single ram with one
// registered read port, and a lookup walks its filled entries one a cycle from
// the lowest index, stopping at the first match. Off-grid neighbour checks and
// lookups on an empty table skip the walk. The result sits in an output
// register, so a new beat is taken while it waits.
// ----------------------------------------------------------------------------
module visited_cell_direction_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// cell_x, cell_y, try_left, try_right, try_up, try_down, heading, zero pad
	input  wire logic [23:0] s_tdata,
	// operation
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// found, exhausted, out_left, out_right, out_up, out_down, table_full, zero
	output logic [7:0]       m_tdata
);
	import vcdt_pkg::*;

	req_t       req;
	logic       req_ready;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;

	assign req.op      = op_t'(s_tuser);
	assign req.col     = coord_t'(s_tdata[7:0]);
	assign req.row     = coord_t'(s_tdata[15:8]);
	assign req.flags   = s_tdata[19:16];
	assign req.heading = heading_t'(s_tdata[21:20]);

	vcdt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign s_tready  = req_ready;
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {1'b0, res.full, res.flags, res.exhausted, res.found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// visited cell direction table testbench
// drives lookups, stores and neighbour checks through the stream ports and
// compares every result beat with a cycle-free model of the table, under
// phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vcdt_pkg::*;

	class direction_table_model;
		coord_t      cols[TABLE_ENTRIES];
		coord_t      rows[TABLE_ENTRIES];
		flags_t      flags[TABLE_ENTRIES];
		int unsigned filled;
		res_t        pending_results[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			filled = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function int find_cell(coord_t c, coord_t r);
			for (int i = 0; i < filled; i++) begin
				if (cols[i] == c && rows[i] == r)
					return i;
			end
			return -1;
		endfunction

		function void accept_request(req_t q);
			coord_t c;
			coord_t r;
			res_t   e;
			int     hit;
			logic   on_grid;
			c = q.col;
			r = q.row;
			e = '0;
			on_grid = 1'b1;
			if (q.op == OP_STORE) begin
				hit = find_cell(c, r);
				e.found = (hit >= 0);
				if (hit >= 0) begin
					flags[hit] = q.flags;
				end else if (filled < TABLE_ENTRIES) begin
					cols[filled] = c;
					rows[filled] = r;
					flags[filled] = q.flags;
					filled++;
				end else begin
					e.full = 1'b1;
				end
			end else begin
				if (q.op == OP_NEIGHBOR) begin
					case (q.heading)
						HEAD_LEFT: begin
							if (c == '0) on_grid = 1'b0; else c = c - 1'b1;
						end
						HEAD_RIGHT: begin
							if (c == '1) on_grid = 1'b0; else c = c + 1'b1;
						end
						HEAD_UP: begin
							if (r == '0) on_grid = 1'b0; else r = r - 1'b1;
						end
						default: begin
							if (r == '1) on_grid = 1'b0; else r = r + 1'b1;
						end
					endcase
				end
				hit = on_grid ? find_cell(c, r) : -1;
				if (hit >= 0) begin
					e.found = 1'b1;
					e.flags = flags[hit];
					e.exhausted = (flags[hit] == '0);
				end else begin
					e.flags = '1;
				end
			end
			pending_results.push_back(e);
		endfunction

		task report_mismatch(string what);
			if (mismatches < 50)
				$display("[%0t] result %0d: %s", $time, results_seen, what);
			mismatches++;
		endtask

		task compare_response(logic [7:0] beat);
			res_t got;
			res_t want;
			got = res_t'(beat[6:0]);
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat %h", beat));
				return;
			end
			want = pending_results.pop_front();
			if (got.found != want.found)
				report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
			if (got.exhausted != want.exhausted)
				report_mismatch($sformatf("exhausted %0b, want %0b",
					got.exhausted, want.exhausted));
			for (int k = 0; k < 4; k++) begin
				if (got.flags[k] != want.flags[k])
					report_mismatch($sformatf("flag bit %0d is %0b, want %0b",
						k, got.flags[k], want.flags[k]));
			end
			if (got.full != want.full)
				report_mismatch($sformatf("table_full %0b, want %0b", got.full, want.full));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	int send_idle_pct;
	int recv_stall_pct;

	direction_table_model table_model = new();

	visited_cell_direction_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			table_model.compare_response(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task send_request(req_t q);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= q.op;
		s_tdata  <= {2'b00, q.heading, q.flags, q.row, q.col};
		do
			@(posedge clk);
		while (!s_tready);
		table_model.accept_request(q);
	endtask

	task send_cell(op_t op, coord_t x, coord_t y, flags_t f, heading_t h);
		req_t q;
		q.op = op;
		q.col = x;
		q.row = y;
		q.flags = f;
		q.heading = h;
		send_request(q);
	endtask

	task wait_for_results();
		s_tvalid <= 1'b0;
		while (table_model.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function coord_t edge_coord();
		case ($urandom_range(4))
			0: return '0;
			1: return coord_t'(1);
			2: return '1;
			3: return {COORD_BITS{1'b1}} - 1'b1;
			default: return coord_t'($urandom());
		endcase
	endfunction

	// mostly cells that are known or next to known ones, so hits and
	// neighbour matches are common; the rest are edges and random cells
	function req_t pick_request();
		req_t q;
		int   pick;
		int   i;
		pick = $urandom_range(99);
		if (pick < 35) q.op = OP_STORE;
		else if (pick < 55) q.op = OP_LOAD;
		else if (pick < 75) q.op = OP_CHECK;
		else q.op = OP_NEIGHBOR;
		q.flags = ($urandom_range(3) == 0) ? flags_t'(0) : flags_t'($urandom_range(15));
		q.heading = heading_t'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 80 && table_model.filled > 0) begin
			i = $urandom_range(table_model.filled - 1);
			q.col = table_model.cols[i];
			q.row = table_model.rows[i];
			if (pick >= 55) begin
				case ($urandom_range(3))
					0: q.col = q.col - 1'b1;
					1: q.col = q.col + 1'b1;
					2: q.row = q.row - 1'b1;
					default: q.row = q.row + 1'b1;
				endcase
			end
		end else if (pick < 90) begin
			q.col = edge_coord();
			q.row = edge_coord();
		end else begin
			q.col = coord_t'($urandom());
			q.row = coord_t'($urandom());
		end
		return q;
	endfunction

	initial begin
		int send_pct[4];
		int recv_pct[4];
		send_pct = '{0, 57, 0, 18};
		recv_pct = '{0, 0, 57, 18};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_STORE;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, off-grid neighbours, corners, updates and exhausted cells
		send_cell(OP_LOAD,     8'd0,   8'd0,   4'b0000, HEAD_LEFT);
		send_cell(OP_CHECK,    8'd255, 8'd255, 4'b1111, HEAD_DOWN);
		send_cell(OP_STORE,    8'd0,   8'd0,   4'b1111, HEAD_DOWN);
		send_cell(OP_NEIGHBOR, 8'd0,   8'd0,   4'b1010, HEAD_LEFT);
		send_cell(OP_NEIGHBOR, 8'd255, 8'd5,   4'b0101, HEAD_RIGHT);
		send_cell(OP_NEIGHBOR, 8'd0,   8'd0,   4'b0000, HEAD_UP);
		send_cell(OP_NEIGHBOR, 8'd5,   8'd255, 4'b1111, HEAD_DOWN);
		send_cell(OP_STORE,    8'd255, 8'd255, 4'b0000, HEAD_UP);
		send_cell(OP_CHECK,    8'd255, 8'd255, 4'b0000, HEAD_LEFT);
		send_cell(OP_LOAD,     8'd255, 8'd255, 4'b1111, HEAD_RIGHT);
		send_cell(OP_NEIGHBOR, 8'd254, 8'd255, 4'b0000, HEAD_RIGHT);
		send_cell(OP_NEIGHBOR, 8'd255, 8'd254, 4'b0000, HEAD_DOWN);
		send_cell(OP_NEIGHBOR, 8'd1,   8'd0,   4'b0000, HEAD_LEFT);
		send_cell(OP_NEIGHBOR, 8'd0,   8'd1,   4'b0000, HEAD_UP);
		send_cell(OP_STORE,    8'd0,   8'd0,   4'b0101, HEAD_LEFT);
		send_cell(OP_LOAD,     8'd0,   8'd0,   4'b1111, HEAD_LEFT);
		send_cell(OP_STORE,    8'd0,   8'd255, 4'b1010, HEAD_RIGHT);
		send_cell(OP_LOAD,     8'd0,   8'd255, 4'b0000, HEAD_UP);
		send_cell(OP_CHECK,    8'd0,   8'd255, 4'b0000, HEAD_UP);
		send_cell(OP_STORE,    8'd255, 8'd0,   4'b0000, HEAD_DOWN);
		send_cell(OP_CHECK,    8'd255, 8'd0,   4'b1111, HEAD_DOWN);
		send_cell(OP_STORE,    8'd255, 8'd0,   4'b1000, HEAD_DOWN);
		send_cell(OP_CHECK,    8'd255, 8'd0,   4'b1111, HEAD_DOWN);
		wait_for_results();

		// table fills during the early phases, the later ones run it full
		for (int phase = 0; phase < 8; phase++) begin
			send_idle_pct = send_pct[phase % 4];
			recv_stall_pct = recv_pct[phase % 4];
			repeat (212)
				send_request(pick_request());
			wait_for_results();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (100) @(posedge clk);
		if (table_model.mismatches == 0)
			$display("** visited_cell_direction_table: PASSED **");
		else
			$display("** visited_cell_direction_table: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** visited_cell_direction_table: FAILED **");
		$finish;
	end

endmodule

@@ visited_cell_direction_table.f @@
sv/vcdt_pkg.sv
sv/vcdt_ram.sv
sv/vcdt_engine.sv
sv/visited_cell_direction_table.sv
test/testbench.sv
